>>> src/hsk_pkg.sv
package hsk_pkg;

	// Number of tracked key slots and number of slots shown in a report.
	localparam int KEY_SLOTS   = 6;
	localparam int OUT_SLOTS   = 6;
	localparam int SHOWN_SLOTS = (KEY_SLOTS < OUT_SLOTS) ? KEY_SLOTS : OUT_SLOTS;
	localparam int SLOT_IW     = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam int MOD_BITS    = 8;

	// Usage codes that drive the modifier byte.
	localparam logic [7:0] MOD_FIRST = 8'hE0;
	localparam logic [7:0] MOD_LAST  = 8'hE7;

	// Request kinds carried by req_type.
	localparam logic REQ_KEY  = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// Control from the slot sequencer to the modifier bank.
	typedef struct packed {
		logic              evt_we;
		logic [2:0]        bit_idx;
		logic signed [7:0] hold;
		logic              tick;
	} mod_ctl_t;

	// One tick of countdown: a positive timer decrements, others stay.
	function automatic logic signed [7:0] timer_step(input logic signed [7:0] t);
		if (t > 8'sd0) begin
			return t - 8'sd1;
		end
		return t;
	endfunction

endpackage

>>> src/hsk_mod_bank.sv
module hsk_mod_bank (
	input  logic                             clk,
	input  logic                             arst_n,
	input  hsk_pkg::mod_ctl_t                ctl,
	output logic [hsk_pkg::MOD_BITS-1:0]     mod_bits
);

	logic [hsk_pkg::MOD_BITS-1:0] mod_q;
	logic signed [7:0]            timer_q [hsk_pkg::MOD_BITS];
	logic [hsk_pkg::MOD_BITS-1:0] live_nz;

	// Bits that are live according to the current timers.
	always_comb begin
		for (int k = 0; k < hsk_pkg::MOD_BITS; k++) begin
			live_nz[k] = (timer_q[k] != 8'sd0);
		end
	end

	// A key event loads one timer; a tick counts all eight down in parallel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= '0;
			for (int k = 0; k < hsk_pkg::MOD_BITS; k++) begin
				timer_q[k] <= 8'sd0;
			end
		end else if (ctl.tick) begin
			for (int k = 0; k < hsk_pkg::MOD_BITS; k++) begin
				timer_q[k] <= hsk_pkg::timer_step(timer_q[k]);
				mod_q[k]   <= (hsk_pkg::timer_step(timer_q[k]) != 8'sd0);
			end
		end else if (ctl.evt_we) begin
			timer_q[ctl.bit_idx] <= ctl.hold;
			if (ctl.hold != 8'sd0) begin
				mod_q[ctl.bit_idx] <= 1'b1;
			end
		end
	end

	assign mod_bits = mod_q;

	// After a tick every modifier bit follows its timer.
	a_tick_sync: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.tick |=> (mod_q == live_nz))
		else $error("modifier bits out of step with timers after tick");

endmodule

>>> src/hid_six_key_report_builder_top.sv
// Six-key-rollover keyboard report builder. A key event (req_type 0) with a
// usage code 0xE0-0xE7 updates the modifier byte as it is accepted; any other
// nonzero code walks the key slots, one slot per cycle, taking the first slot
// that holds the same code or has an expired timer. A report tick (req_type 1)
// is accepted, then compares the report with the last one sent and loads the
// output register when it changed, then makes a countdown and compaction
// pass over every slot through the shared slot step logic. A tick whose report
// changed waits in the compare state while the previous report still sits
// unclaimed in the output register. in_ready is high only between items.
module hid_six_key_report_builder_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic [7:0]        key_code,
	input  logic signed [7:0] hold_count,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        modifier_bits,
	output logic [7:0]        slot_key_0,
	output logic [7:0]        slot_key_1,
	output logic [7:0]        slot_key_2,
	output logic [7:0]        slot_key_3,
	output logic [7:0]        slot_key_4,
	output logic [7:0]        slot_key_5
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_CMP,
		S_CNT
	} state_t;

	localparam logic [hsk_pkg::SLOT_IW-1:0] LAST_IDX = hsk_pkg::SLOT_IW'(hsk_pkg::KEY_SLOTS - 1);

	state_t                       state_q;
	logic [hsk_pkg::SLOT_IW-1:0]  idx_q;
	logic [hsk_pkg::SLOT_IW-1:0]  wr_q;
	logic [7:0]                   code_q;
	logic signed [7:0]            hold_q;
	logic [7:0]                   key_q     [hsk_pkg::KEY_SLOTS];
	logic signed [7:0]            timer_q   [hsk_pkg::KEY_SLOTS];
	logic [7:0]                   last_key_q[hsk_pkg::KEY_SLOTS];
	logic [7:0]                   last_mod_q;
	logic                         out_valid_q;
	logic [7:0]                   out_mod_q;
	logic [7:0]                   out_key_q [hsk_pkg::OUT_SLOTS];

	hsk_pkg::mod_ctl_t            mod_ctl;
	logic [7:0]                   mod_bits;
	logic                         in_acc;
	logic                         is_mod;
	logic                         scan_hit;
	logic signed [7:0]            cnt_next;
	logic                         differ;
	logic                         out_free;
	logic                         cmp_go;
	logic                         out_load;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign is_mod   = (key_code >= hsk_pkg::MOD_FIRST) && (key_code <= hsk_pkg::MOD_LAST);

	// Shared slot step: match test for a key event, countdown for a tick.
	assign scan_hit = (key_q[idx_q] == code_q) || (timer_q[idx_q] == 8'sd0);
	assign cnt_next = hsk_pkg::timer_step(timer_q[idx_q]);

	// Report compare against the last word sent.
	always_comb begin
		differ = (mod_bits != last_mod_q);
		for (int i = 0; i < hsk_pkg::KEY_SLOTS; i++) begin
			if (key_q[i] != last_key_q[i]) begin
				differ = 1'b1;
			end
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign cmp_go   = (state_q == S_CMP) && (!differ || out_free);
	assign out_load = cmp_go && differ;

	// Modifier bank control.
	always_comb begin
		mod_ctl.evt_we  = in_acc && (req_type == hsk_pkg::REQ_KEY) && is_mod;
		mod_ctl.bit_idx = key_code[2:0];
		mod_ctl.hold    = hold_count;
		mod_ctl.tick    = cmp_go;
	end

	hsk_mod_bank u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mod_ctl),
		.mod_bits (mod_bits)
	);

	// Sequencer, slot store and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			wr_q        <= '0;
			code_q      <= '0;
			hold_q      <= 8'sd0;
			last_mod_q  <= '0;
			out_valid_q <= 1'b0;
			out_mod_q   <= '0;
			for (int i = 0; i < hsk_pkg::KEY_SLOTS; i++) begin
				key_q[i]      <= '0;
				timer_q[i]    <= 8'sd0;
				last_key_q[i] <= '0;
			end
			for (int j = 0; j < hsk_pkg::OUT_SLOTS; j++) begin
				out_key_q[j] <= '0;
			end
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						idx_q  <= '0;
						wr_q   <= '0;
						code_q <= key_code;
						hold_q <= hold_count;
						if (req_type == hsk_pkg::REQ_TICK) begin
							state_q <= S_CMP;
						end else if (!is_mod && (key_code != 8'h00)) begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_hit) begin
						if (hold_q != 8'sd0) begin
							key_q[idx_q] <= code_q;
						end
						timer_q[idx_q] <= hold_q;
						state_q        <= S_IDLE;
					end else if (idx_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + hsk_pkg::SLOT_IW'(1);
					end
				end
				S_CMP: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						out_mod_q   <= mod_bits;
						last_mod_q  <= mod_bits;
						for (int i = 0; i < hsk_pkg::KEY_SLOTS; i++) begin
							last_key_q[i] <= key_q[i];
						end
						for (int j = hsk_pkg::SHOWN_SLOTS; j < hsk_pkg::OUT_SLOTS; j++) begin
							out_key_q[j] <= '0;
						end
						for (int j = 0; j < hsk_pkg::SHOWN_SLOTS; j++) begin
							out_key_q[j] <= key_q[j];
						end
					end
					if (cmp_go) begin
						state_q <= S_CNT;
					end
				end
				S_CNT: begin
					// A live slot drops to the lowest free slot; a dead one clears.
					if (cnt_next != 8'sd0) begin
						timer_q[wr_q] <= cnt_next;
						key_q[wr_q]   <= key_q[idx_q];
						if (wr_q != idx_q) begin
							timer_q[idx_q] <= 8'sd0;
							key_q[idx_q]   <= '0;
						end
						wr_q <= wr_q + hsk_pkg::SLOT_IW'(1);
					end else begin
						timer_q[idx_q] <= 8'sd0;
						key_q[idx_q]   <= '0;
					end
					if (idx_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + hsk_pkg::SLOT_IW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign modifier_bits = out_mod_q;
	assign slot_key_0    = out_key_q[0];
	assign slot_key_1    = out_key_q[1];
	assign slot_key_2    = out_key_q[2];
	assign slot_key_3    = out_key_q[3];
	assign slot_key_4    = out_key_q[4];
	assign slot_key_5    = out_key_q[5];

	// A report that was just sent becomes the reference for the next compare.
	a_last_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (last_mod_q == modifier_bits) && out_valid)
		else $error("last sent report does not match emitted word");

	// The compaction write pointer never runs ahead of the slot being counted.
	a_wr_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CNT) |-> (wr_q <= idx_q))
		else $error("compaction pointer ahead of slot index");

	// The slot index stays inside the slot store.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= LAST_IDX)
		else $error("slot index out of range");

endmodule
